@@ rtl/indexed_array_list_engine_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the indexed array list engine
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define INDEXED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define IALE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iale check failed");

// next-cycle implication
`define IALE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iale check failed");

`endif

@@ rtl/iale_pkg.sv @@
// ----------------------------------------------------------------------------
// iale_pkg
// Transaction types, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package iale_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int FND_W  = 6;
  localparam int CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [FND_W-1:0]         found_position;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_FIND_RD,
    S_FIND_CMP,
    S_GET_RD,
    S_GET_CAP
  } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/iale_store.sv @@
// ----------------------------------------------------------------------------
// iale_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iale_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [iale_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [iale_pkg::DATA_W-1:0] rdata
);

  logic [iale_pkg::DATA_W-1:0] mem [DEPTH];
  logic [iale_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/iale_ctrl.sv @@
// ----------------------------------------------------------------------------
// iale_ctrl
// Sequencer: decodes a transaction, walks the entry memory step by step
// through a shared index stepper and a find comparator, builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module iale_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire iale_pkg::in_item_t          in_data,
  output logic                             in_ready,
  input  wire logic                        slot_free,
  output logic                             res_valid,
  output iale_pkg::out_item_t              res_data,
  output logic                             mem_we,
  output logic      [AW-1:0]               mem_waddr,
  output logic      [iale_pkg::DATA_W-1:0] mem_wdata,
  output logic      [AW-1:0]               mem_raddr,
  input  wire logic [iale_pkg::DATA_W-1:0] mem_rdata
);

  localparam int CMPW = (CW > iale_pkg::POS_W) ? CW : iale_pkg::POS_W;
  localparam int FW   = iale_pkg::FND_W;
  localparam int OW   = iale_pkg::CNT_W;

  iale_pkg::seq_state_t state_r, state_nxt;
  logic                        done_r, done_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               bound_r, bound_nxt;
  logic                        up_r, up_nxt;
  logic [iale_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [iale_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [FW-1:0]               fnd_r, fnd_nxt;
  logic [iale_pkg::DATA_W-1:0] rd_r, rd_nxt;

  logic [CW-1:0]   idx_step;
  logic            step_end;
  logic            data_hit;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;

  assign idx_step = up_r ? (idx_r - CW'(1)) : (idx_r + CW'(1));
  assign step_end = (idx_step == bound_r);
  assign data_hit = (mem_rdata == val_r);
  assign pos_ext  = CMPW'(in_data.position);
  assign cnt_ext  = CMPW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iale_pkg::S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    bound_r <= bound_nxt;
    up_r    <= up_nxt;
    val_r   <= val_nxt;
    stat_r  <= stat_nxt;
    fnd_r   <= fnd_nxt;
    rd_r    <= rd_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    bound_nxt = bound_r;
    up_nxt    = up_r;
    val_nxt   = val_r;
    stat_nxt  = stat_r;
    fnd_nxt   = fnd_r;
    rd_nxt    = rd_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = val_r;
    mem_raddr = idx_r[AW-1:0];
    res_valid = 1'b0;
    in_ready  = 1'b0;

    case (state_r)
      iale_pkg::S_IDLE: begin
        if (done_r) begin
          // hold the result until the output register frees up
          if (slot_free) begin
            res_valid = 1'b1;
            done_nxt  = 1'b0;
          end
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            val_nxt  = in_data.data_value;
            stat_nxt = iale_pkg::ST_OK;
            fnd_nxt  = '0;
            rd_nxt   = '0;
            up_nxt   = 1'b0;
            done_nxt = 1'b1;
            case (in_data.opcode)
              iale_pkg::OP_INSERT: begin
                if (pos_ext > cnt_ext) begin
                  stat_nxt = iale_pkg::ST_BAD_INDEX;
                end else if (cnt_r == CW'(CAPACITY)) begin
                  stat_nxt = iale_pkg::ST_FULL;
                end else begin
                  done_nxt  = 1'b0;
                  up_nxt    = 1'b1;
                  idx_nxt   = cnt_r;
                  bound_nxt = CW'(pos_ext);
                  cnt_nxt   = cnt_r + CW'(1);
                  state_nxt = (pos_ext == cnt_ext) ? iale_pkg::S_PUT
                                                   : iale_pkg::S_MOVE_RD;
                end
              end
              iale_pkg::OP_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                  stat_nxt = iale_pkg::ST_BAD_INDEX;
                end else begin
                  idx_nxt   = CW'(pos_ext);
                  bound_nxt = cnt_r - CW'(1);
                  cnt_nxt   = cnt_r - CW'(1);
                  if ((pos_ext + CMPW'(1)) != cnt_ext) begin
                    done_nxt  = 1'b0;
                    state_nxt = iale_pkg::S_MOVE_RD;
                  end
                end
              end
              iale_pkg::OP_FIND: begin
                stat_nxt = iale_pkg::ST_NOT_FOUND;
                if (cnt_r != '0) begin
                  done_nxt  = 1'b0;
                  idx_nxt   = '0;
                  bound_nxt = cnt_r;
                  state_nxt = iale_pkg::S_FIND_RD;
                end
              end
              iale_pkg::OP_GET: begin
                if (pos_ext >= cnt_ext) begin
                  stat_nxt = iale_pkg::ST_BAD_INDEX;
                end else begin
                  done_nxt  = 1'b0;
                  idx_nxt   = CW'(pos_ext);
                  state_nxt = iale_pkg::S_GET_RD;
                end
              end
              iale_pkg::OP_UPDATE: begin
                if (pos_ext >= cnt_ext) begin
                  stat_nxt = iale_pkg::ST_BAD_INDEX;
                end else begin
                  done_nxt  = 1'b0;
                  idx_nxt   = CW'(pos_ext);
                  state_nxt = iale_pkg::S_PUT;
                end
              end
              default: begin
                stat_nxt = iale_pkg::ST_BAD_INDEX;
              end
            endcase
          end
        end
      end

      iale_pkg::S_MOVE_RD: begin
        mem_raddr = idx_step[AW-1:0];
        state_nxt = iale_pkg::S_MOVE_WR;
      end

      iale_pkg::S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_step;
        if (!step_end) begin
          state_nxt = iale_pkg::S_MOVE_RD;
        end else if (up_r) begin
          state_nxt = iale_pkg::S_PUT;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = iale_pkg::S_IDLE;
        end
      end

      iale_pkg::S_PUT: begin
        mem_we    = 1'b1;
        done_nxt  = 1'b1;
        state_nxt = iale_pkg::S_IDLE;
      end

      iale_pkg::S_FIND_RD: begin
        state_nxt = iale_pkg::S_FIND_CMP;
      end

      iale_pkg::S_FIND_CMP: begin
        if (data_hit) begin
          stat_nxt  = iale_pkg::ST_OK;
          fnd_nxt   = FW'(idx_r);
          done_nxt  = 1'b1;
          state_nxt = iale_pkg::S_IDLE;
        end else if (step_end) begin
          done_nxt  = 1'b1;
          state_nxt = iale_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_step;
          state_nxt = iale_pkg::S_FIND_RD;
        end
      end

      iale_pkg::S_GET_RD: begin
        state_nxt = iale_pkg::S_GET_CAP;
      end

      iale_pkg::S_GET_CAP: begin
        rd_nxt    = mem_rdata;
        done_nxt  = 1'b1;
        state_nxt = iale_pkg::S_IDLE;
      end

      default: begin
        state_nxt = iale_pkg::S_IDLE;
      end
    endcase
  end

  assign res_data = '{status:         stat_r,
                      found_position: fnd_r,
                      read_value:     rd_r,
                      entry_count:    OW'(cnt_r)};

endmodule

`default_nettype wire

@@ rtl/indexed_array_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// indexed_array_list_engine_core
// Ordered list of signed 32-bit entries with insert, delete, find, get and
// update, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// One transaction at a time: in_ready is high only while the sequencer is
// idle, and a finished result waits in the output register so the next
// transaction can be taken meanwhile. The entry memory has one read and one
// write port with registered read data, so each entry moved by insert or
// delete takes a read state and a write state, and each entry compared by
// find a read state and a compare state. Insert then writes the new entry,
// get reads and then captures the entry, update writes it, and a rejected
// transaction finishes in the idle state; each result is then handed to the
// output register. The worst case from one accepted transaction to the next
// is a find over a full list. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_array_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire iale_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output iale_pkg::out_item_t     out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                        slot_free;
  logic                        res_valid;
  iale_pkg::out_item_t         res_data;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [iale_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [iale_pkg::DATA_W-1:0] mem_rdata;

  logic                out_valid_r;
  iale_pkg::out_item_t out_data_r;

  iale_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  iale_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/iale_checker.sv @@
// ----------------------------------------------------------------------------
// iale_checker
// Port-level checks for the list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_array_list_engine_core_defines.svh"

module iale_checker #(
  parameter int CAPACITY = 64
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire iale_pkg::out_item_t out_data
);

  localparam int OW = iale_pkg::CNT_W;
  localparam logic [OW-1:0] FULL_CNT = OW'(CAPACITY);

  logic err_out;
  logic err_fields_zero;
  logic full_out;
  logic full_cnt_hit;

  assign err_out         = out_valid && (out_data.status != iale_pkg::ST_OK);
  assign err_fields_zero = (out_data.found_position == '0) && (out_data.read_value == '0);
  assign full_out        = out_valid && (out_data.status == iale_pkg::ST_FULL);
  assign full_cnt_hit    = (out_data.entry_count == FULL_CNT);

  `IALE_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `IALE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `IALE_ASSERT_IMP(a_err_zero, err_out, err_fields_zero)
  `IALE_ASSERT_IMP(a_full_count, full_out, full_cnt_hit)

endmodule

bind indexed_array_list_engine_core iale_checker #(
  .CAPACITY (CAPACITY)
) u_iale_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
